### design/apis_pkg.sv
// Shared types, codes and constants of the adaptive poll interval scheduler.
package apis_pkg;

   localparam int FRACTION_BITS      = 5;
   localparam int MAX_WHOLE_INTERVAL = 256;

   localparam int INTERVAL_WIDTH = 14;
   localparam int COUNT_WIDTH    = 9;
   localparam int COUNTER_WIDTH  = 9;
   localparam int CSR_DATA_WIDTH = 14;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int SUM_WIDTH      = 17;

   localparam logic [INTERVAL_WIDTH-1:0] MAX_INTERVAL =
      INTERVAL_WIDTH'(MAX_WHOLE_INTERVAL << FRACTION_BITS);
   localparam logic [INTERVAL_WIDTH-1:0] RESET_INTERVAL =
      INTERVAL_WIDTH'(16 << FRACTION_BITS);
   localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX = '1;

   localparam logic [CSR_DATA_WIDTH-1:0] ICP_AVG_RESET  = 14'd192;
   localparam logic [CSR_DATA_WIDTH-1:0] ICP_MIN_RESET  = 14'd256;
   localparam logic [CSR_DATA_WIDTH-1:0] DNS_AVG_RESET  = 14'd128;
   localparam logic [CSR_DATA_WIDTH-1:0] DNS_MIN_RESET  = 14'd256;
   localparam logic [CSR_DATA_WIDTH-1:0] HTTP_AVG_RESET = 14'd128;
   localparam logic [CSR_DATA_WIDTH-1:0] HTTP_MIN_RESET = 14'd256;

   typedef enum logic {
      OP_EVENT  = 1'b0,
      OP_REPORT = 1'b1
   } apis_op_type;

   typedef enum logic [1:0] {
      CLASS_ICP  = 2'd0,
      CLASS_DNS  = 2'd1,
      CLASS_HTTP = 2'd2
   } apis_class_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ICP_AVG  = 3'd0,
      REG_ICP_MIN  = 3'd1,
      REG_DNS_AVG  = 3'd2,
      REG_DNS_MIN  = 3'd3,
      REG_HTTP_AVG = 3'd4,
      REG_HTTP_MIN = 3'd5
   } apis_reg_type;

   typedef struct packed {
      logic                          tick;
      logic                          report;
      logic signed [COUNT_WIDTH-1:0] count;
   } apis_cmd_type;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] average_goal;
      logic [CSR_DATA_WIDTH-1:0] min_interval;
      logic                      hold_negative;
   } apis_class_cfg_type;

endpackage

### design/apis_if.sv
// Request and response channel interfaces of the adaptive poll interval scheduler.
interface apis_req_if import apis_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [1:0]                    report_class;
   logic signed [COUNT_WIDTH-1:0] event_count;

   modport source (output valid, opcode, report_class, event_count, input ready);
   modport sink (input valid, opcode, report_class, event_count, output ready);
endinterface

interface apis_rsp_if import apis_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      due_icp;
   logic                      due_dns;
   logic                      due_http;
   logic [INTERVAL_WIDTH-1:0] icp_interval_now;
   logic [INTERVAL_WIDTH-1:0] dns_interval_now;
   logic [INTERVAL_WIDTH-1:0] http_interval_now;

   modport source (output valid, due_icp, due_dns, due_http, icp_interval_now,
                   dns_interval_now, http_interval_now, input ready);
   modport sink (input valid, due_icp, due_dns, due_http, icp_interval_now,
                 dns_interval_now, http_interval_now, output ready);
endinterface

### design/apis_class_unit.sv
// Event counter and adaptive interval of one socket class.
module apis_class_unit import apis_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  apis_cmd_type              cmd,
   input  apis_class_cfg_type        cfg,
   output logic                      due,
   output logic [INTERVAL_WIDTH-1:0] interval_next
);

   logic [COUNTER_WIDTH-1:0]  counter_ff, counter_in;
   logic [INTERVAL_WIDTH-1:0] interval_ff, interval_in;
   logic [COUNTER_WIDTH-1:0]  counter_inc;
   logic [INTERVAL_WIDTH-1:0] whole;
   logic signed [SUM_WIDTH-1:0] sum;
   logic signed [SUM_WIDTH-1:0] raised;
   logic signed [SUM_WIDTH-1:0] min_ext;
   logic signed [SUM_WIDTH-1:0] max_ext;
   logic [INTERVAL_WIDTH-1:0]   clamped;

   assign whole       = interval_ff >> FRACTION_BITS;
   assign counter_inc = (counter_ff == COUNTER_MAX) ? counter_ff
                                                    : counter_ff + 1'b1;
   assign due = cmd.tick && ({{(INTERVAL_WIDTH-COUNTER_WIDTH){1'b0}}, counter_inc} > whole);

   assign min_ext = $signed({{(SUM_WIDTH-CSR_DATA_WIDTH){1'b0}}, cfg.min_interval});
   assign max_ext = $signed({{(SUM_WIDTH-INTERVAL_WIDTH){1'b0}}, MAX_INTERVAL});
   assign sum = $signed({{(SUM_WIDTH-INTERVAL_WIDTH){1'b0}}, interval_ff})
              + $signed({{(SUM_WIDTH-CSR_DATA_WIDTH){1'b0}}, cfg.average_goal})
              - $signed({{(SUM_WIDTH-COUNT_WIDTH){cmd.count[COUNT_WIDTH-1]}}, cmd.count});
   assign raised  = (sum < min_ext) ? min_ext : sum;
   assign clamped = (raised > max_ext) ? MAX_INTERVAL : raised[INTERVAL_WIDTH-1:0];

   always_comb begin
      counter_in  = counter_ff;
      interval_in = interval_ff;
      if (cmd.tick) begin
         counter_in = due ? '0 : counter_inc;
      end else if (cmd.report) begin
         counter_in = '0;
         if (!(cfg.hold_negative && cmd.count[COUNT_WIDTH-1])) begin
            interval_in = clamped;
         end
      end
   end

   assign interval_next = interval_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         interval_ff <= RESET_INTERVAL;
      end else if (step) begin
         counter_ff  <= counter_in;
         interval_ff <= interval_in;
      end
   end

   a_due_clears: assert property (@(posedge clock) disable iff (reset)
      step && due |=> counter_ff == '0)
      else $error("counter not cleared after due");

   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      step && cmd.report && !cmd.tick |=> counter_ff == '0)
      else $error("counter not cleared after report");

   a_interval_max: assert property (@(posedge clock) disable iff (reset)
      interval_ff <= MAX_INTERVAL)
      else $error("interval above maximum");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(interval_ff) && $stable(counter_ff))
      else $error("state changed without a step");

endmodule

### design/adaptive_poll_interval_scheduler.sv
// Top level of the adaptive poll interval scheduler: request, class units, response registers.
//
// Each request is an io event or a poll report and yields one response that
// shows the due flags and the three intervals after the request. A request
// is taken into an input register, passes combinationally through the three
// class units and lands in the response register, so one request per cycle
// is sustained while the response port does not stall. Control registers are
// to be written by the user through the csr port while the block is idle; the
// block itself does not enforce this. Writes to indexes above five are ignored.
module adaptive_poll_interval_scheduler import apis_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   apis_req_if.sink                   req_port,
   apis_rsp_if.source                 rsp_port,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                          in_valid_ff;
   logic                          in_opcode_ff;
   logic [1:0]                    in_class_ff;
   logic signed [COUNT_WIDTH-1:0] in_count_ff;

   logic                      out_valid_ff;
   logic                      due_icp_ff, due_dns_ff, due_http_ff;
   logic [INTERVAL_WIDTH-1:0] icp_iv_ff, dns_iv_ff, http_iv_ff;

   logic [CSR_DATA_WIDTH-1:0] icp_avg_ff, icp_min_ff, dns_avg_ff, dns_min_ff;
   logic [CSR_DATA_WIDTH-1:0] http_avg_ff, http_min_ff;

   logic                      advance;
   logic                      is_report;
   apis_cmd_type              icp_cmd, dns_cmd, http_cmd;
   apis_class_cfg_type        icp_cfg, dns_cfg, http_cfg;
   logic                      icp_due, dns_due, http_due;
   logic [INTERVAL_WIDTH-1:0] icp_iv, dns_iv, http_iv;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_opcode_ff <= req_port.opcode;
         in_class_ff  <= req_port.report_class;
         in_count_ff  <= req_port.event_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icp_avg_ff  <= ICP_AVG_RESET;
         icp_min_ff  <= ICP_MIN_RESET;
         dns_avg_ff  <= DNS_AVG_RESET;
         dns_min_ff  <= DNS_MIN_RESET;
         http_avg_ff <= HTTP_AVG_RESET;
         http_min_ff <= HTTP_MIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ICP_AVG:  icp_avg_ff  <= csr_write_data;
            REG_ICP_MIN:  icp_min_ff  <= csr_write_data;
            REG_DNS_AVG:  dns_avg_ff  <= csr_write_data;
            REG_DNS_MIN:  dns_min_ff  <= csr_write_data;
            REG_HTTP_AVG: http_avg_ff <= csr_write_data;
            REG_HTTP_MIN: http_min_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign is_report = (in_opcode_ff == OP_REPORT);

   always_comb begin
      icp_cmd.tick    = !is_report;
      icp_cmd.report  = is_report && (in_class_ff == CLASS_ICP);
      icp_cmd.count   = in_count_ff;
      dns_cmd.tick    = !is_report;
      dns_cmd.report  = is_report && (in_class_ff == CLASS_DNS);
      dns_cmd.count   = in_count_ff;
      http_cmd.tick   = !is_report;
      http_cmd.report = is_report && (in_class_ff == CLASS_HTTP);
      http_cmd.count  = in_count_ff;
   end

   assign icp_cfg  = '{average_goal: icp_avg_ff, min_interval: icp_min_ff,
                       hold_negative: 1'b0};
   assign dns_cfg  = '{average_goal: dns_avg_ff, min_interval: dns_min_ff,
                       hold_negative: 1'b1};
   assign http_cfg = '{average_goal: http_avg_ff, min_interval: http_min_ff,
                       hold_negative: 1'b0};

   apis_class_unit u_icp (
      .clock, .reset, .step(advance), .cmd(icp_cmd), .cfg(icp_cfg),
      .due(icp_due), .interval_next(icp_iv)
   );

   apis_class_unit u_dns (
      .clock, .reset, .step(advance), .cmd(dns_cmd), .cfg(dns_cfg),
      .due(dns_due), .interval_next(dns_iv)
   );

   apis_class_unit u_http (
      .clock, .reset, .step(advance), .cmd(http_cmd), .cfg(http_cfg),
      .due(http_due), .interval_next(http_iv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_port.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         due_icp_ff  <= icp_due;
         due_dns_ff  <= dns_due;
         due_http_ff <= http_due;
         icp_iv_ff   <= icp_iv;
         dns_iv_ff   <= dns_iv;
         http_iv_ff  <= http_iv;
      end
   end

   assign rsp_port.valid             = out_valid_ff;
   assign rsp_port.due_icp           = due_icp_ff;
   assign rsp_port.due_dns           = due_dns_ff;
   assign rsp_port.due_http          = due_http_ff;
   assign rsp_port.icp_interval_now  = icp_iv_ff;
   assign rsp_port.dns_interval_now  = dns_iv_ff;
   assign rsp_port.http_interval_now = http_iv_ff;

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_port.ready |=> in_valid_ff)
      else $error("pending request lost during response stall");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response register not loaded");

   a_report_no_due: assert property (@(posedge clock) disable iff (reset)
      advance && is_report |=> !due_icp_ff && !due_dns_ff && !due_http_ff)
      else $error("due flag raised on a report request");

endmodule
